@@ rtl/mbrd_pkg.sv @@
`default_nettype none

package mbrd_pkg;

   // Request opcodes
   localparam logic [1:0] OP_SEND    = 2'd0;
   localparam logic [1:0] OP_RX_BYTE = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // Result kinds
   localparam logic KIND_TX_BYTE = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Verdict status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;

   // Framer status toward the top level
   typedef struct packed {
      logic       busy;
      logic [7:0] data;
      logic       last;
   } framer_out_type;

   // Reflected CRC-16 update over one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mbrd_framer.sv @@
`default_nettype none

module mbrd_framer
   import mbrd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire logic [7:0]  slave_address,
   input  wire logic [15:0] register_address,
   input  wire logic [15:0] register_count,
   input  wire logic        advance,
   output framer_out_type   tx
);

   logic        busy_ff, busy_in;
   logic [2:0]  index_ff, index_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  addr_ff, addr_in;
   logic [15:0] reg_ff, reg_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  cur_byte;
   logic        cur_last;

   // Byte at the current frame position; CRC bytes go low first
   always_comb begin
      case (index_ff)
         3'd0:    cur_byte = addr_ff;
         3'd1:    cur_byte = FUNC_READ_HOLDING;
         3'd2:    cur_byte = reg_ff[15:8];
         3'd3:    cur_byte = reg_ff[7:0];
         3'd4:    cur_byte = cnt_ff[15:8];
         3'd5:    cur_byte = cnt_ff[7:0];
         3'd6:    cur_byte = crc_ff[7:0];
         default: cur_byte = crc_ff[15:8];
      endcase
   end

   assign cur_last = (index_ff == 3'd7);

   // Next state: load a new frame or step one byte
   always_comb begin
      busy_in  = busy_ff;
      index_in = index_ff;
      crc_in   = crc_ff;
      addr_in  = addr_ff;
      reg_in   = reg_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         busy_in  = 1'b1;
         index_in = 3'd0;
         crc_in   = CRC_INIT;
         addr_in  = slave_address;
         reg_in   = register_address;
         cnt_in   = register_count;
      end else if (advance && busy_ff) begin
         index_in = index_ff + 3'd1;
         if (index_ff < 3'd6) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end
         if (cur_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= 3'd0;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
      crc_ff  <= crc_in;
      addr_ff <= addr_in;
      reg_ff  <= reg_in;
      cnt_ff  <= cnt_in;
   end

   assign tx.busy = busy_ff;
   assign tx.data = cur_byte;
   assign tx.last = cur_last;

endmodule

`default_nettype wire

@@ rtl/modbus_read_request_framer_checker.sv @@
// A last response byte or a timeout gives its verdict in the cycle after acceptance;
// a send request first loads the framer, which then steps its eight frame bytes one at a
// time into the result register as the result slot frees.
// Throughput: one response byte or timeout per cycle while the result slot is free; a send
// holds the input while the framer walks the frame one byte per cycle as the slot frees.
// Reset (synchronous, active high): no result pending, framer idle, CRC at FFFF,
// byte count, held bytes and value cleared.
`default_nettype none

module modbus_read_request_framer_checker
   import mbrd_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [7:0]         req_slave_address,
   input  wire logic [15:0]        req_register_address,
   input  wire logic [15:0]        req_register_count,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               req_rx_last,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic               rsp_result_kind,
   output      logic [7:0]         rsp_tx_byte,
   output      logic signed [31:0] rsp_read_value,
   output      logic [1:0]         rsp_status,
   output      logic               rsp_last_of_run
);

   localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

   framer_out_type tx;
   logic           out_free;
   logic           accept;
   logic           advance;
   logic           load;

   // Response checker state
   logic [15:0]      crc_ff, crc_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       held0_ff, held0_in;
   logic [7:0]       held1_ff, held1_in;
   logic [31:0]      acc_ff, acc_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  txb_ff, txb_in;
   logic [31:0] value_ff, value_in;
   logic [1:0]  status_ff, status_in;
   logic        last_ff, last_in;

   // Handshake: result slot free, framer not walking a frame
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !tx.busy && out_free;
   assign accept    = req_valid && req_ready;
   assign advance   = tx.busy && out_free;
   assign load      = accept && (req_opcode == OP_SEND);

   mbrd_framer u_framer (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .slave_address    (req_slave_address),
      .register_address (req_register_address),
      .register_count   (req_register_count),
      .advance          (advance),
      .tx               (tx)
   );

   // Response byte path and verdict
   always_comb begin
      logic [15:0]      crc_n;
      logic [IDX_W-1:0] idx_n;
      logic [7:0]       h0_n;
      logic [7:0]       h1_n;
      logic [31:0]      acc_n;
      logic             ok;

      crc_n = crc_ff;
      idx_n = idx_ff;
      h0_n  = held0_ff;
      h1_n  = held1_ff;
      acc_n = acc_ff;
      ok    = 1'b0;

      crc_in   = crc_ff;
      idx_in   = idx_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      acc_in   = acc_ff;

      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      txb_in       = txb_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      last_in      = last_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Byte accepted below the buffer size: fold the oldest held byte
      if (idx_ff < IDX_W'(MAX_FRAME_BYTES)) begin
         if (idx_ff >= IDX_W'(2)) begin
            crc_n = crc_byte(crc_ff, held0_ff);
            if (idx_ff >= IDX_W'(5)) begin
               acc_n = {acc_ff[23:0], held0_ff};
            end
         end
         h0_n  = held1_ff;
         h1_n  = req_rx_byte;
         idx_n = idx_ff + IDX_W'(1);
      end
      ok = (idx_n >= IDX_W'(3)) && (h0_n == crc_n[7:0]) && (h1_n == crc_n[15:8]);

      if (advance) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_TX_BYTE;
         txb_in       = tx.data;
         value_in     = 32'd0;
         status_in    = STATUS_OK;
         last_in      = tx.last;
      end else if (accept) begin
         case (req_opcode)
            OP_SEND: begin
               crc_in   = CRC_INIT;
               idx_in   = '0;
               held0_in = 8'd0;
               held1_in = 8'd0;
               acc_in   = 32'd0;
            end
            OP_TIMEOUT: begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_VERDICT;
               txb_in       = 8'd0;
               value_in     = 32'd0;
               status_in    = STATUS_TIMEOUT;
               last_in      = 1'b1;
               crc_in       = CRC_INIT;
               idx_in       = '0;
               held0_in     = 8'd0;
               held1_in     = 8'd0;
               acc_in       = 32'd0;
            end
            OP_RX_BYTE: begin
               if (req_rx_last) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_VERDICT;
                  txb_in       = 8'd0;
                  value_in     = ok ? acc_n : 32'd0;
                  status_in    = ok ? STATUS_OK : STATUS_CRC_ERR;
                  last_in      = 1'b1;
                  crc_in       = CRC_INIT;
                  idx_in       = '0;
                  held0_in     = 8'd0;
                  held1_in     = 8'd0;
                  acc_in       = 32'd0;
               end else begin
                  crc_in   = crc_n;
                  idx_in   = idx_n;
                  held0_in = h0_n;
                  held1_in = h1_n;
                  acc_in   = acc_n;
               end
            end
            default: begin
               // unused opcode: no effect
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         crc_ff       <= CRC_INIT;
         idx_ff       <= '0;
         held0_ff     <= 8'd0;
         held1_ff     <= 8'd0;
         acc_ff       <= 32'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         idx_ff       <= idx_in;
         held0_ff     <= held0_in;
         held1_ff     <= held1_in;
         acc_ff       <= acc_in;
      end
      kind_ff   <= kind_in;
      txb_ff    <= txb_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_tx_byte     = txb_ff;
   assign rsp_read_value  = value_ff;
   assign rsp_status      = status_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

@@ bench/tb_modbus_read_request_framer_checker.sv @@
`timescale 1ns / 1ps

module tb_modbus_read_request_framer_checker;
   import mbrd_pkg::*;

   localparam int         FRAME_LIMIT = 128;
   localparam int         STALL_LIMIT = 2000;
   localparam int         LONG_HOLD   = 300;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   // One request as offered on the input channel, with an optional typed-in verdict
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  sa;
      logic [15:0] ra;
      logic [15:0] rc;
      logic [7:0]  rb;
      logic        rl;
      logic        typed;
      logic        verdict;
      logic [1:0]  status;
   } stim_row_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx;
      logic [31:0] value;
      logic [1:0]  status;
      logic        last;
   } master_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_opcode;
   logic [7:0]         req_slave_address;
   logic [15:0]        req_register_address;
   logic [15:0]        req_register_count;
   logic [7:0]         req_rx_byte;
   logic               req_rx_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_result_kind;
   logic [7:0]         rsp_tx_byte;
   logic signed [31:0] rsp_read_value;
   logic [1:0]         rsp_status;
   logic               rsp_last_of_run;

   // Shadow state of the response checker
   logic [15:0] mm_crc;
   int          mm_count;
   logic [7:0]  mm_held [2];
   logic [31:0] mm_value;

   master_result_type awaited [$];
   master_result_type pred_buf [8];
   int                pred_count;

   int error_count = 0;
   int items_sent = 0;
   int tally_tx = 0;
   int tally_ok = 0;
   int tally_timeout = 0;
   int tally_crc = 0;
   int idle_cycles = 0;
   bit no_gaps = 1'b0;
   bit hold_rsp = 1'b0;

   // Directed requests: expected verdicts typed in where obvious
   stim_row_type directed_rows [0:12] = '{
      // timeout straight out of reset
      '{OP_TIMEOUT, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, STATUS_TIMEOUT},
      // unused opcode gives nothing
      '{OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0, STATUS_OK},
      '{OP_SEND, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK},
      '{OP_SEND, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b0, STATUS_OK},
      '{OP_SEND, 8'h01, 16'h006B, 16'h0003, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK},
      // one-byte response is short
      '{OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, STATUS_CRC_ERR},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'hFF, 1'b0, 1'b1, 1'b0, STATUS_OK},
      // two-byte response is short
      '{OP_RX_BYTE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hA5, 1'b1, 1'b1, 1'b1, STATUS_CRC_ERR},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h11, 1'b0, 1'b1, 1'b0, STATUS_OK},
      // timeout in the middle of a response
      '{OP_TIMEOUT, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, STATUS_TIMEOUT},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h12, 1'b0, 1'b1, 1'b0, STATUS_OK},
      // send drops the partial response
      '{OP_SEND, 8'h5A, 16'h1234, 16'h0002, 8'h34, 1'b0, 1'b0, 1'b0, STATUS_OK},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, STATUS_CRC_ERR}
   };

   modbus_read_request_framer_checker #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_slave_address(req_slave_address),
      .req_register_address(req_register_address),
      .req_register_count(req_register_count),
      .req_rx_byte(req_rx_byte),
      .req_rx_last(req_rx_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_read_value(rsp_read_value),
      .rsp_status(rsp_status),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Bit-serial reflected CRC-16, one data bit per step
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ b[k];
         r = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic stim_row_type random_row(input logic [1:0] op);
      stim_row_type s;
      s.op = op;
      s.sa = 8'($urandom);
      s.ra = 16'($urandom);
      s.rc = 16'($urandom);
      s.rb = 8'($urandom);
      s.rl = 1'($urandom);
      s.typed = 1'b0;
      s.verdict = 1'b0;
      s.status = STATUS_OK;
      return s;
   endfunction

   function automatic stim_row_type rx_row(input logic [7:0] b, input logic l);
      stim_row_type s;
      s = random_row(OP_RX_BYTE);
      s.rb = b;
      s.rl = l;
      return s;
   endfunction

   task automatic clear_response();
      mm_crc = CRC_INIT;
      mm_count = 0;
      mm_held[0] = 8'h00;
      mm_held[1] = 8'h00;
      mm_value = 32'd0;
   endtask

   // Predict the results of one accepted request into pred_buf
   task automatic predict_master(input stim_row_type s);
      logic [7:0]  fb [8];
      logic [15:0] c;
      logic        good;
      pred_count = 0;
      case (s.op)
         OP_SEND: begin
            fb = '{s.sa, FUNC_READ_HOLDING, s.ra[15:8], s.ra[7:0],
                   s.rc[15:8], s.rc[7:0], 8'h00, 8'h00};
            c = CRC_INIT;
            for (int i = 0; i < 6; i++) begin
               c = crc_step(c, fb[i]);
            end
            fb[6] = c[7:0];
            fb[7] = c[15:8];
            for (int i = 0; i < 8; i++) begin
               pred_buf[i] = '{KIND_TX_BYTE, fb[i], 32'd0, STATUS_OK, 1'(i == 7)};
            end
            pred_count = 8;
            clear_response();
         end
         OP_TIMEOUT: begin
            pred_buf[0] = '{KIND_VERDICT, 8'h00, 32'd0, STATUS_TIMEOUT, 1'b1};
            pred_count = 1;
            clear_response();
         end
         OP_RX_BYTE: begin
            // bytes past the buffer size are dropped
            if (mm_count < FRAME_LIMIT) begin
               if (mm_count >= 2) begin
                  mm_crc = crc_step(mm_crc, mm_held[0]);
                  if (mm_count >= 5) begin
                     mm_value = {mm_value[23:0], mm_held[0]};
                  end
               end
               mm_held[0] = mm_held[1];
               mm_held[1] = s.rb;
               mm_count++;
            end
            if (s.rl) begin
               good = mm_count >= 3 && mm_held[0] == mm_crc[7:0] && mm_held[1] == mm_crc[15:8];
               if (good) begin
                  pred_buf[0] = '{KIND_VERDICT, 8'h00, mm_value, STATUS_OK, 1'b1};
               end else begin
                  pred_buf[0] = '{KIND_VERDICT, 8'h00, 32'd0, STATUS_CRC_ERR, 1'b1};
               end
               pred_count = 1;
               clear_response();
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      if (error_count < 40) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   // Offer one request after a random gap (none when no_gaps is set); predict once it is accepted
   task automatic drive_request(input stim_row_type s);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= s.op;
      req_slave_address <= s.sa;
      req_register_address <= s.ra;
      req_register_count <= s.rc;
      req_rx_byte <= s.rb;
      req_rx_last <= s.rl;
      do @(posedge clock); while (!req_ready);
      if (s.op != OP_UNUSED) begin
         items_sent++;
      end
      predict_master(s);
      if (s.typed) begin
         if (s.verdict) begin
            awaited.push_back('{KIND_VERDICT, 8'h00, 32'd0, s.status, 1'b1});
         end
      end else begin
         for (int i = 0; i < pred_count; i++) begin
            awaited.push_back(pred_buf[i]);
         end
      end
   endtask

   // Sender holds off until every expected result is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited.size() != 0);
   endtask

   // Response of body_len bytes plus its CRC; optional corruption, early end and padding
   task automatic send_response(input int body_len, input bit corrupt, input int cut,
                                input int pad, input bit close);
      logic [7:0]  fr [$];
      logic [15:0] c;
      int          idx;
      int          stop;
      for (int i = 0; i < body_len; i++) begin
         if (body_len >= 3 && i == 1) begin
            fr.push_back(FUNC_READ_HOLDING);
         end else if (body_len >= 3 && i == 2) begin
            fr.push_back(8'(body_len - 3));
         end else begin
            fr.push_back(8'($urandom));
         end
      end
      c = CRC_INIT;
      foreach (fr[i]) begin
         c = crc_step(c, fr[i]);
      end
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      if (corrupt) begin
         idx = $urandom_range(0, fr.size() - 1);
         fr[idx] = fr[idx] ^ 8'(1 << $urandom_range(0, 7));
      end
      repeat (pad) fr.push_back(8'($urandom));
      stop = (cut > 0 && cut < fr.size()) ? cut : fr.size();
      for (int i = 0; i < stop; i++) begin
         drive_request(rx_row(fr[i], close && i == stop - 1));
      end
   endtask

   // Receiver: random stall per result (none when no_gaps is set), one long hold-off on request
   initial begin : rsp_sink
      int stall;
      rsp_ready = 1'b0;
      forever begin
         if (hold_rsp) begin
            stall = LONG_HOLD;
            hold_rsp = 1'b0;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Result checker
   always @(posedge clock) begin : rsp_monitor
      master_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d tx %h status %0d",
                                      rsp_result_kind, rsp_tx_byte, rsp_status));
         end else begin
            want = awaited.pop_front();
            check_field("result_kind", 32'(rsp_result_kind), 32'(want.kind));
            check_field("tx_byte", 32'(rsp_tx_byte), 32'(want.tx));
            check_field("read_value", rsp_read_value, want.value);
            check_field("status", 32'(rsp_status), 32'(want.status));
            check_field("last_of_run", 32'(rsp_last_of_run), 32'(want.last));
            if (want.kind == KIND_TX_BYTE) begin
               tally_tx++;
            end else if (want.status == STATUS_OK) begin
               tally_ok++;
            end else if (want.status == STATUS_TIMEOUT) begin
               tally_timeout++;
            end else begin
               tally_crc++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_type s;
      int           iter;
      int           pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_SEND;
      req_slave_address = 8'h00;
      req_register_address = 16'h0000;
      req_register_count = 16'h0000;
      req_rx_byte = 8'h00;
      req_rx_last = 1'b0;
      clear_response();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, then a few hand-picked responses
      foreach (directed_rows[i]) begin
         drive_request(directed_rows[i]);
      end
      send_response(1, 1'b0, 0, 0, 1'b1);
      send_response(7, 1'b0, 0, 0, 1'b1);
      send_response(3, 1'b1, 0, 0, 1'b1);

      // random part, mostly well-formed responses
      iter = 0;
      while (items_sent < 440) begin
         iter++;
         if ($urandom_range(0, 9) == 0) begin
            no_gaps = !no_gaps;
         end
         if (iter == 5 || iter == 22) begin
            // receiver stalls long while sends pile up
            hold_rsp = 1'b1;
            repeat (4) drive_request(random_row(OP_SEND));
         end else if (iter == 3) begin
            // fills the buffer exactly, extra bytes dropped
            send_response(FRAME_LIMIT - 2, 1'b0, 0, 2, 1'b1);
         end else if (iter == 9) begin
            send_response(FRAME_LIMIT, 1'b0, 0, 0, 1'b1);
         end else if (iter % 15 == 0) begin
            wait_for_drain();
            send_response(3 + $urandom_range(0, 8), 1'b0, 0, 0, 1'b1);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_response(3 + $urandom_range(0, 8), 1'b0, 0, 0, 1'b1);
            end else if (pick < 55) begin
               send_response(1 + $urandom_range(0, 10), 1'b1, 0, 0, 1'b1);
            end else if (pick < 63) begin
               send_response(3 + $urandom_range(0, 8), 1'b0, $urandom_range(1, 12), 0, 1'b1);
            end else if (pick < 73) begin
               s = random_row(OP_SEND);
               if ($urandom_range(0, 7) == 0) begin
                  s.sa = 8'hFF;
                  s.ra = 16'hFFFF;
                  s.rc = 16'hFFFF;
               end else if ($urandom_range(0, 7) == 0) begin
                  s.sa = 8'h00;
                  s.ra = 16'h0000;
                  s.rc = 16'h0000;
               end
               drive_request(s);
            end else if (pick < 79) begin
               drive_request(random_row(OP_TIMEOUT));
            end else if (pick < 84) begin
               // response cut off by a timeout or a new send
               send_response(3 + $urandom_range(0, 8), 1'b0, $urandom_range(1, 10), 0, 1'b0);
               drive_request(random_row($urandom_range(0, 1) ? OP_TIMEOUT : OP_SEND));
            end else if (pick < 91) begin
               drive_request(random_row(OP_RX_BYTE));
            end else if (pick < 95) begin
               drive_request(random_row(OP_UNUSED));
            end else begin
               // bodies too short for a header, some under three bytes in all
               send_response($urandom_range(0, 2), 1'b0, 0, 0, 1'b1);
            end
         end
      end

      wait_for_drain();
      repeat (12) @(posedge clock);
      $display("Covered %0d requests: %0d frame bytes; verdicts ok %0d, timeout %0d, crc/short %0d",
               items_sent, tally_tx, tally_ok, tally_timeout, tally_crc);
      $display("including buffer overflow, long receiver hold-off and drained pauses");
      if (error_count == 0 && awaited.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
